// File: hdl/two_way_writeback_cache_unit_defines.svh
// assertion macros for the two-way write-back cache unit
// used by the modules that carry concurrent checks; no other dependencies
`ifndef TWO_WAY_WRITEBACK_CACHE_UNIT_DEFINES_SVH
`define TWO_WAY_WRITEBACK_CACHE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// check a property on the rising clock, ignored while reset is high
`define TWWBC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cache check failed");
// check a property on the rising clock, also during reset
`define TWWBC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("cache check failed");
`else
`define TWWBC_ASSERT(name, clk, rst, prop)
`define TWWBC_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: hdl/twwbc_pkg.sv
// shared types and constants of the two-way write-back cache unit
// no dependencies; imported by the controller, the datapath and the top level
package twwbc_pkg;

   // fixed field widths and default geometry
   localparam int ADDR_W           = 24;
   localparam int DEF_SETS         = 64;
   localparam int DEF_LINE_BYTES   = 32;

   // request operations
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FILL  = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;

   // response kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_WB    = 2'd2;
   localparam logic [1:0] KIND_FREQ  = 2'd3;

   typedef struct packed {
      logic [1:0]        operation;
      logic [ADDR_W-1:0] address;
      logic [2:0]        access_size;
      logic [31:0]       write_data;
      logic [31:0]       fill_word;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [31:0]       read_data;
      logic              hit;
      logic [ADDR_W-1:0] mem_address;
      logic [31:0]       mem_data;
      logic              last;
   } rsp_type;

   // commands from controller to datapath
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_FILL,
      CMD_FILL_LAST,
      CMD_LOOKUP,
      CMD_WB_READ,
      CMD_WB_EMIT,
      CMD_FILL_REQ,
      CMD_ACC_RD0,
      CMD_ACC_RD1,
      CMD_ACC_MOD,
      CMD_ACC_WR1,
      CMD_RESP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_access;
      logic is_fill;
      logic pend_valid;
      logic fill_last;
      logic hit;
      logic victim_dirty;
      logic wb_last;
      logic is_write;
      logic out_free;
   } sts_type;

endpackage

// File: hdl/twwbc_ctrl.sv
// controller state machine of the two-way write-back cache unit
// depends on twwbc_pkg for command and status types
module twwbc_ctrl import twwbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_LOOKUP, S_WB_RD, S_WB_EMIT, S_FILL_REQ,
      S_ACC_RD0, S_ACC_RD1, S_ACC_MOD, S_ACC_WR1, S_ACC_RESP
   } state_type;

   state_type state_ff, state_in;

   // requests are taken only while idle
   assign req_stall = (state_ff != S_IDLE);

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd.op   = CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (sts.is_fill && sts.pend_valid) begin
                  if (sts.fill_last) begin
                     cmd.op   = CMD_FILL_LAST;
                     state_in = S_ACC_RD0;
                  end else begin
                     cmd.op = CMD_FILL;
                  end
               end else if (sts.is_access && !sts.pend_valid) begin
                  cmd.op   = CMD_CAPTURE;
                  state_in = S_LOOKUP;
               end
            end
         end
         S_LOOKUP: begin
            cmd.op = CMD_LOOKUP;
            if (sts.hit) state_in = S_ACC_RD0;
            else if (sts.victim_dirty) state_in = S_WB_RD;
            else state_in = S_FILL_REQ;
         end
         S_WB_RD: begin
            cmd.op   = CMD_WB_READ;
            state_in = S_WB_EMIT;
         end
         S_WB_EMIT: begin
            if (sts.out_free) begin
               cmd.op   = CMD_WB_EMIT;
               state_in = sts.wb_last ? S_FILL_REQ : S_WB_RD;
            end else begin
               // keep the writeback word on the read port while waiting
               cmd.op = CMD_WB_READ;
            end
         end
         S_FILL_REQ: begin
            if (sts.out_free) begin
               cmd.op   = CMD_FILL_REQ;
               state_in = S_IDLE;
            end
         end
         S_ACC_RD0: begin
            cmd.op   = CMD_ACC_RD0;
            state_in = S_ACC_RD1;
         end
         S_ACC_RD1: begin
            cmd.op   = CMD_ACC_RD1;
            state_in = S_ACC_MOD;
         end
         S_ACC_MOD: begin
            cmd.op   = CMD_ACC_MOD;
            state_in = sts.is_write ? S_ACC_WR1 : S_ACC_RESP;
         end
         S_ACC_WR1: begin
            cmd.op   = CMD_ACC_WR1;
            state_in = S_ACC_RESP;
         end
         S_ACC_RESP: begin
            if (sts.out_free) begin
               cmd.op   = CMD_RESP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/twwbc_dpath.sv
// datapath of the two-way write-back cache unit: tag and data memories,
// state bits, pending access and response register; depends on twwbc_pkg
`include "two_way_writeback_cache_unit_defines.svh"
module twwbc_dpath import twwbc_pkg::*; #(
   parameter int SETS       = DEF_SETS,
   parameter int LINE_BYTES = DEF_LINE_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  logic    rsp_stall,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int OB    = $clog2(LINE_BYTES);
   localparam int IB    = $clog2(SETS);
   localparam int TB    = ADDR_W - OB - IB;
   localparam int WORDS = LINE_BYTES / 4;
   localparam int WB    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SLOTS = SETS * 2;
   localparam int DEPTH = SLOTS * (1 << WB);

   req_type           acc_ff;
   logic              pend_ff;
   logic [WB-1:0]     fill_cnt_ff, wb_idx_ff;
   logic              way_ff, hit_ff;
   logic [TB-1:0]     tag_mem0 [SETS];
   logic [TB-1:0]     tag_mem1 [SETS];
   logic [TB-1:0]     tag0_ff, tag1_ff;
   logic [31:0]       data_mem [DEPTH];
   logic [31:0]       data_rd_ff, lo_ff, hi_ff, rd_ff;
   logic [SLOTS-1:0]  valid_ff, dirty_ff, lru_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [IB-1:0]     set_w;
   logic [TB-1:0]     tag_w, vtag;
   logic [WB-1:0]     word0, word1;
   logic              hit0, hit1, hit, hit_way, victim, is_write, out_free;
   logic [2:0]        n4, nb;
   logic [OB:0]       room;
   logic [3:0]        m4;
   logic [7:0]        bm8;
   logic [63:0]       mask64, win, wd64, merged;
   logic [31:0]       rdmask, rd_word;
   logic [5:0]        sh;
   logic              mem_we;
   logic [$clog2(DEPTH)-1:0] mem_wa, mem_ra;
   logic [31:0]       mem_wd;

   // address fields of the captured or pending access
   assign set_w = acc_ff.address[OB +: IB];
   assign tag_w = acc_ff.address[OB+IB +: TB];
   assign word0 = WB'((acc_ff.address >> 2) & ADDR_W'(WORDS - 1));
   assign word1 = word0 + 1'b1;
   assign is_write = (acc_ff.operation == OP_WRITE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // tag compare and victim choice
   assign hit0    = valid_ff[{set_w, 1'b0}] && (tag0_ff == tag_w);
   assign hit1    = valid_ff[{set_w, 1'b1}] && (tag1_ff == tag_w);
   assign hit     = hit0 || hit1;
   assign hit_way = !hit0;
   assign victim  = !lru_ff[{set_w, 1'b0}];
   assign vtag    = way_ff ? tag1_ff : tag0_ff;

   // byte count clamped to four and to the end of the line
   always_comb begin
      n4   = (acc_ff.access_size > 3'd4) ? 3'd4 : acc_ff.access_size;
      room = (OB+1)'(LINE_BYTES) - {1'b0, acc_ff.address[OB-1:0]};
      nb   = (room < (OB+1)'(n4)) ? room[2:0] : n4;
      case (nb)
         3'd0:    m4 = 4'h0;
         3'd1:    m4 = 4'h1;
         3'd2:    m4 = 4'h3;
         3'd3:    m4 = 4'h7;
         default: m4 = 4'hF;
      endcase
      bm8 = {4'b0, m4} << acc_ff.address[1:0];
      for (int i = 0; i < 8; i++) begin
         mask64[i*8 +: 8] = {8{bm8[i]}};
      end
      for (int i = 0; i < 4; i++) begin
         rdmask[i*8 +: 8] = {8{m4[i]}};
      end
   end

   // two-word window merge and extract
   assign sh      = {1'b0, acc_ff.address[1:0], 3'b0};
   assign win     = {data_rd_ff, lo_ff};
   assign rd_word = 32'(win >> sh) & rdmask;
   assign wd64    = {32'b0, acc_ff.write_data} << sh;
   assign merged  = (win & ~mask64) | (wd64 & mask64);

   // data memory port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = {set_w, way_ff, word0};
      mem_wd = merged[31:0];
      mem_ra = {set_w, way_ff, word0};
      case (cmd.op)
         CMD_FILL, CMD_FILL_LAST: begin
            mem_we = 1'b1;
            mem_wa = {set_w, way_ff, fill_cnt_ff};
            mem_wd = req_data.fill_word;
         end
         CMD_ACC_MOD: mem_we = is_write;
         CMD_ACC_WR1: begin
            mem_we = 1'b1;
            mem_wa = {set_w, way_ff, word1};
            mem_wd = hi_ff;
         end
         default: mem_we = 1'b0;
      endcase
      case (cmd.op)
         CMD_WB_READ: mem_ra = {set_w, way_ff, wb_idx_ff};
         CMD_ACC_RD1: mem_ra = {set_w, way_ff, word1};
         default:     mem_ra = {set_w, way_ff, word0};
      endcase
   end

   // line data memory
   always_ff @(posedge clock) begin
      if (mem_we) data_mem[mem_wa] <= mem_wd;
      data_rd_ff <= data_mem[mem_ra];
   end

   // tag memories, one per way
   always_ff @(posedge clock) begin
      if (cmd.op == CMD_CAPTURE) begin
         tag0_ff <= tag_mem0[req_data.address[OB +: IB]];
         tag1_ff <= tag_mem1[req_data.address[OB +: IB]];
      end
      if (cmd.op == CMD_FILL_LAST) begin
         if (way_ff) tag_mem1[set_w] <= tag_w;
         else tag_mem0[set_w] <= tag_w;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_CAPTURE: acc_ff <= req_data;
         CMD_FILL_LAST: hit_ff <= 1'b0;
         CMD_LOOKUP: begin
            way_ff <= hit ? hit_way : victim;
            hit_ff <= hit;
         end
         CMD_WB_EMIT: begin
            rsp_ff.kind        <= KIND_WB;
            rsp_ff.read_data   <= '0;
            rsp_ff.hit         <= 1'b0;
            rsp_ff.mem_address <= {vtag, set_w, OB'(0)} + (ADDR_W'(wb_idx_ff) << 2);
            rsp_ff.mem_data    <= data_rd_ff;
            rsp_ff.last        <= 1'b0;
         end
         CMD_FILL_REQ: begin
            rsp_ff.kind        <= KIND_FREQ;
            rsp_ff.read_data   <= '0;
            rsp_ff.hit         <= 1'b0;
            rsp_ff.mem_address <= {acc_ff.address[ADDR_W-1:OB], OB'(0)};
            rsp_ff.mem_data    <= '0;
            rsp_ff.last        <= 1'b1;
         end
         CMD_ACC_RD1: lo_ff <= data_rd_ff;
         CMD_ACC_MOD: begin
            hi_ff <= merged[63:32];
            rd_ff <= is_write ? 32'b0 : rd_word;
         end
         CMD_RESP: begin
            rsp_ff.kind        <= is_write ? KIND_WRITE : KIND_READ;
            rsp_ff.read_data   <= rd_ff;
            rsp_ff.hit         <= hit_ff;
            rsp_ff.mem_address <= '0;
            rsp_ff.mem_data    <= '0;
            rsp_ff.last        <= 1'b1;
         end
         default: hit_ff <= hit_ff;
      endcase
   end

   // control state: line state bits, pending fill, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         lru_ff       <= '0;
         pend_ff      <= 1'b0;
         fill_cnt_ff  <= '0;
         wb_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new response is loaded or the current one drains
         if ((cmd.op == CMD_WB_EMIT) || (cmd.op == CMD_FILL_REQ) || (cmd.op == CMD_RESP))
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
         case (cmd.op)
            CMD_FILL: fill_cnt_ff <= fill_cnt_ff + 1'b1;
            CMD_FILL_LAST: begin
               fill_cnt_ff               <= '0;
               pend_ff                   <= 1'b0;
               valid_ff[{set_w, way_ff}] <= 1'b1;
               dirty_ff[{set_w, way_ff}] <= 1'b0;
            end
            CMD_LOOKUP: begin
               wb_idx_ff <= '0;
               if (hit) begin
                  lru_ff[{set_w, hit_way}]  <= 1'b0;
                  lru_ff[{set_w, !hit_way}] <= 1'b1;
               end else begin
                  lru_ff[{set_w, victim}]   <= 1'b0;
                  lru_ff[{set_w, !victim}]  <= 1'b1;
                  valid_ff[{set_w, victim}] <= 1'b0;
                  dirty_ff[{set_w, victim}] <= 1'b0;
               end
            end
            CMD_WB_EMIT: wb_idx_ff <= wb_idx_ff + 1'b1;
            CMD_FILL_REQ: begin
               pend_ff     <= 1'b1;
               fill_cnt_ff <= '0;
            end
            CMD_ACC_MOD: begin
               if (is_write) dirty_ff[{set_w, way_ff}] <= 1'b1;
            end
            default: pend_ff <= pend_ff;
         endcase
      end
   end

   // status to the controller
   assign sts.is_access    = (req_data.operation == OP_READ) ||
                             (req_data.operation == OP_WRITE);
   assign sts.is_fill      = (req_data.operation == OP_FILL);
   assign sts.pend_valid   = pend_ff;
   assign sts.fill_last    = (fill_cnt_ff == WB'(WORDS - 1));
   assign sts.hit          = hit;
   assign sts.victim_dirty = dirty_ff[{set_w, victim}];
   assign sts.wb_last      = (wb_idx_ff == WB'(WORDS - 1));
   assign sts.is_write     = is_write;
   assign sts.out_free     = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `TWWBC_ASSERT(a_cnt_needs_pend, clock, reset, (fill_cnt_ff != '0) |-> pend_ff)
   `TWWBC_ASSERT(a_pend_with_freq, clock, reset, $rose(pend_ff) |-> (rsp_valid_ff && rsp_ff.kind == KIND_FREQ && rsp_ff.last))
   `TWWBC_ASSERT(a_fill_done_clears, clock, reset, (cmd.op == CMD_FILL_LAST) |=> !pend_ff)
   `TWWBC_ASSERT(a_no_emit_when_full, clock, reset, ((cmd.op == CMD_RESP) || (cmd.op == CMD_WB_EMIT) || (cmd.op == CMD_FILL_REQ)) |-> out_free)

endmodule

// File: hdl/two_way_writeback_cache_unit.sv
// Two-way set-associative write-back cache with one LRU bit per way in front of
// a byte-addressed backing memory. Requests are read, write (1 to 4 bytes,
// clamped at the line end) or fill word. One request is handled at a time: a
// hit passes the tag memory read, the lookup and a two-word read-modify-write
// on the line memory, which has one read and one write port. A miss writes
// back a dirty victim word by word, each word read and then emitted, and ends
// with a fill request; fill words are taken one per cycle and the last one
// completes the pending access with the read-modify-write of a hit. Accesses
// arriving while a fill is pending, stray fill words and operation three are
// taken and dropped. Depends on twwbc_pkg, twwbc_ctrl and twwbc_dpath.
module two_way_writeback_cache_unit import twwbc_pkg::*; #(
   parameter int SETS       = DEF_SETS,
   parameter int LINE_BYTES = DEF_LINE_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencing
   twwbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // memories and state
   twwbc_dpath #(
      .SETS       (SETS),
      .LINE_BYTES (LINE_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
